FILE: rtl/core/mrdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrdf_pkg
// Types and constants shared by the mesh repeat duplicate filter modules.
// ----------------------------------------------------------------------------
package mrdf_pkg;

    localparam int ADDR_W  = 8;
    localparam int HOP_W   = 4;
    localparam int FIELD_W = 8;
    localparam int TIME_W  = 32;
    localparam int EXP_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY   = 2'd3;

    localparam logic               RST_RELAY_EN = 1'b1;
    localparam logic [ADDR_W-1:0]  RST_OWN_ADDR = 8'd1;
    localparam logic [HOP_W-1:0]   RST_MAX_HOPS = 4'd3;
    localparam logic [EXP_W-1:0]   RST_EXPIRY   = 16'd2000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // one stored transaction
    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [FIELD_W-1:0] func;
        logic [FIELD_W-1:0] nonce;
        logic [FIELD_W-1:0] reg_addr;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic scan_run;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: rtl/core/mrdf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrdf_in_if
// Packet header channel into the duplicate filter.
// ----------------------------------------------------------------------------
interface mrdf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  dest_addr;
    logic [3:0]  hop_in;
    logic [7:0]  reg_addr;
    logic [7:0]  func_code;
    logic [7:0]  nonce;
    logic [31:0] now_ms;

    modport source (
        output valid, dest_addr, hop_in, reg_addr, func_code, nonce, now_ms,
        input  ready
    );
    modport sink (
        input  valid, dest_addr, hop_in, reg_addr, func_code, nonce, now_ms,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/mrdf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrdf_out_if
// Repeat decision channel out of the duplicate filter.
// ----------------------------------------------------------------------------
interface mrdf_out_if;
    logic       valid;
    logic       ready;
    logic       repeat_res;
    logic [7:0] new_src_addr;
    logic [3:0] hop_out;

    modport source (
        output valid, repeat_res, new_src_addr, hop_out,
        input  ready
    );
    modport sink (
        input  valid, repeat_res, new_src_addr, hop_out,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/mrdf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrdf_ctrl
// Sequencer: accept a header, run the table scan, then hand off the result.
// ----------------------------------------------------------------------------
module mrdf_ctrl
    import mrdf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/mrdf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrdf_dp
// Datapath: configuration registers, header capture, transaction table with
// a one-entry-per-cycle scan, ring write and output register.
// ----------------------------------------------------------------------------
module mrdf_dp
    import mrdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ADDR_W-1:0]     i_dest_addr,
    input  wire logic [HOP_W-1:0]      i_hop_in,
    input  wire logic [FIELD_W-1:0]    i_reg_addr,
    input  wire logic [FIELD_W-1:0]    i_func_code,
    input  wire logic [FIELD_W-1:0]    i_nonce,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_repeat_res,
    output logic [ADDR_W-1:0]          o_new_src_addr,
    output logic [HOP_W-1:0]           o_hop_out
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic              r_relay_en;
    logic [ADDR_W-1:0] r_own_addr;
    logic [HOP_W-1:0]  r_max_hops;
    logic [EXP_W-1:0]  r_expiry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_en <= RST_RELAY_EN;
            r_own_addr <= RST_OWN_ADDR;
            r_max_hops <= RST_MAX_HOPS;
            r_expiry   <= RST_EXPIRY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RELAY_EN: r_relay_en <= i_cfg_data[0];
                CFG_OWN_ADDR: r_own_addr <= i_cfg_data[ADDR_W-1:0];
                CFG_MAX_HOPS: r_max_hops <= i_cfg_data[HOP_W-1:0];
                CFG_EXPIRY:   r_expiry   <= i_cfg_data[EXP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // captured header
    logic [ADDR_W-1:0]  r_dest;
    logic [HOP_W-1:0]   r_hop;
    t_entry             r_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dest        <= i_dest_addr;
            r_hop         <= i_hop_in;
            r_key.time_ms <= i_now_ms;
            r_key.func    <= i_func_code;
            r_key.nonce   <= i_nonce;
            r_key.reg_addr <= i_reg_addr;
        end
    end

    // transaction table
    t_entry             mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]   r_wslot;
    t_entry             r_rd_data;
    logic               r_rd_valid;

    logic [CNT_W-1:0]   r_scan;
    logic               r_pipe;
    logic               r_dup;
    logic               scan_end;
    logic [TIME_W-1:0]  age;
    logic               hit;
    logic               elig;
    logic               rep;

    assign scan_end = (r_scan == CNT_W'(TABLE_DEPTH));
    assign age      = r_key.time_ms - r_rd_data.time_ms;
    assign hit      = r_pipe && r_rd_valid
                      && (r_rd_data.reg_addr == r_key.reg_addr)
                      && (r_rd_data.func == r_key.func)
                      && (r_rd_data.nonce == r_key.nonce)
                      && (age < {{(TIME_W-EXP_W){1'b0}}, r_expiry});
    assign elig     = r_relay_en && (r_dest != r_own_addr) && (r_hop < r_max_hops);
    assign rep      = elig && !r_dup;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && !scan_end) begin
            r_rd_data  <= mem[r_scan[IDX_W-1:0]];
            r_rd_valid <= r_valid[r_scan[IDX_W-1:0]];
        end
        if (i_cmd.finish && rep) begin
            mem[r_wslot] <= r_key;
        end
    end

    // scan sequencing: read stage then compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_pipe <= 1'b0;
            r_dup  <= 1'b0;
        end else if (i_cmd.capture) begin
            r_scan <= '0;
            r_pipe <= 1'b0;
            r_dup  <= 1'b0;
        end else if (i_cmd.scan_run) begin
            if (hit) begin
                r_dup <= 1'b1;
            end
            if (!scan_end) begin
                r_scan <= r_scan + CNT_W'(1);
                r_pipe <= 1'b1;
            end else begin
                r_pipe <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wslot <= '0;
        end else if (i_cmd.finish && rep) begin
            r_valid[r_wslot] <= 1'b1;
            if (r_wslot == IDX_W'(TABLE_DEPTH - 1)) begin
                r_wslot <= '0;
            end else begin
                r_wslot <= r_wslot + IDX_W'(1);
            end
        end
    end

    // output register
    logic              r_out_valid;
    logic              r_out_rep;
    logic [ADDR_W-1:0] r_out_src;
    logic [HOP_W-1:0]  r_out_hop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_rep <= rep;
            r_out_src <= rep ? r_own_addr : '0;
            r_out_hop <= rep ? (r_hop + HOP_W'(1)) : '0;
        end
    end

    assign o_stat.scan_done = scan_end && !r_pipe;
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_repeat_res     = r_out_rep;
    assign o_new_src_addr   = r_out_src;
    assign o_hop_out        = r_out_hop;

endmodule
`default_nettype wire

FILE: rtl/core/mesh_repeat_duplicate_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_repeat_duplicate_filter_top
// Flooding relay duplicate suppression: decides whether a received packet
// is repeated and records repeated transactions in a ring table.
//
// i_in carries one packet header plus the current millisecond time; a
// transfer happens when valid and ready are both high. o_out carries one
// decision per header: repeat flag, new source address and new hop count
// (both zero when the packet is not repeated).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// writes it while no header is in flight, which the block does not enforce;
// index 0 relay enable, 1 own address, 2 max hops, 3 expiry time.
// Each header is captured on its input transfer; the table memory is then read
// one entry per cycle and each entry is compared from the registered read data.
// One header is processed at a time: no new header is accepted until the
// previous result is written to the output register. If the receiver
// stalls, the next header is still accepted and scanned, and only its final
// write waits until the pending result is transferred.
// Reset (synchronous, active low) restores the default configuration and
// clears all table valid marks and the ring write pointer.
// ----------------------------------------------------------------------------
module mesh_repeat_duplicate_filter_top
    import mrdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mrdf_in_if.sink                    i_in,
    mrdf_out_if.source                 o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mrdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mrdf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_dest_addr    (i_in.dest_addr),
        .i_hop_in       (i_in.hop_in),
        .i_reg_addr     (i_in.reg_addr),
        .i_func_code    (i_in.func_code),
        .i_nonce        (i_in.nonce),
        .i_now_ms       (i_in.now_ms),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_repeat_res   (o_out.repeat_res),
        .o_new_src_addr (o_out.new_src_addr),
        .o_hop_out      (o_out.hop_out)
    );

endmodule
`default_nettype wire

FILE: dv/mrdf_decision_checker.sv
// ----------------------------------------------------------------------------
// mrdf_decision_checker
// Watches the header and decision channels and the register write port of
// the duplicate filter. It keeps its own copy of the relay settings and the
// transaction ring, works out the repeat decision for every accepted header,
// and compares each accepted decision field by field with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module mrdf_decision_checker
    import mrdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mrdf_in_if                         i_hdr,
    mrdf_out_if                        i_dec,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              repeat_res;
        logic [ADDR_W-1:0] new_src;
        logic [HOP_W-1:0]  hop_out;
    } decision_t;

    // relay settings as last written
    logic              relay_en;
    logic [ADDR_W-1:0] own_addr;
    logic [HOP_W-1:0]  hop_limit;
    logic [EXP_W-1:0]  expiry;

    // ring of repeated transactions
    logic        seen_valid [TABLE_DEPTH];
    t_entry      seen       [TABLE_DEPTH];
    int unsigned next_slot;

    decision_t awaited_decisions[$];
    int        fail_total = 0;
    int        pending_cnt = 0;
    int        decision_idx = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = pending_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR decision %0d: %s", $realtime, decision_idx, msg);
        fail_total++;
    endtask

    function automatic decision_t relay_decision(
        input logic [ADDR_W-1:0]  dest,
        input logic [HOP_W-1:0]   hop,
        input logic [FIELD_W-1:0] rega,
        input logic [FIELD_W-1:0] func,
        input logic [FIELD_W-1:0] nce,
        input logic [TIME_W-1:0]  now
    );
        decision_t         d;
        logic              dup;
        logic [TIME_W-1:0] age;
        d   = '0;
        dup = 1'b0;
        if (relay_en && dest != own_addr && hop < hop_limit) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (seen_valid[k] && seen[k].reg_addr == rega && seen[k].func == func &&
                    seen[k].nonce == nce) begin
                    // wrapping age, so a time stamp just before the wrap still matches
                    age = now - seen[k].time_ms;
                    if (age < TIME_W'(expiry)) dup = 1'b1;
                end
            end
            if (!dup) begin
                seen_valid[next_slot]       = 1'b1;
                seen[next_slot].time_ms     = now;
                seen[next_slot].func        = func;
                seen[next_slot].nonce       = nce;
                seen[next_slot].reg_addr    = rega;
                next_slot    = (next_slot + 1 == TABLE_DEPTH) ? 0 : next_slot + 1;
                d.repeat_res = 1'b1;
                d.new_src    = own_addr;
                d.hop_out    = hop + 4'd1;
            end
        end
        return d;
    endfunction

    always @(posedge i_clk) begin
        decision_t want;
        if (!i_rst_n) begin
            relay_en  = RST_RELAY_EN;
            own_addr  = RST_OWN_ADDR;
            hop_limit = RST_MAX_HOPS;
            expiry    = RST_EXPIRY;
            for (int k = 0; k < TABLE_DEPTH; k++) seen_valid[k] = 1'b0;
            next_slot = 0;
            awaited_decisions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RELAY_EN: relay_en  = i_cfg_data[0];
                    CFG_OWN_ADDR: own_addr  = i_cfg_data[ADDR_W-1:0];
                    CFG_MAX_HOPS: hop_limit = i_cfg_data[HOP_W-1:0];
                    CFG_EXPIRY:   expiry    = i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_dec.valid && i_dec.ready) begin
                if (awaited_decisions.size() == 0) begin
                    report_mismatch("decision transfer with none awaited");
                end else begin
                    want = awaited_decisions.pop_front();
                    if (i_dec.repeat_res !== want.repeat_res)
                        report_mismatch($sformatf("repeat_res got %b want %b",
                                                  i_dec.repeat_res, want.repeat_res));
                    if (i_dec.new_src_addr !== want.new_src)
                        report_mismatch($sformatf("new_src_addr got %0h want %0h",
                                                  i_dec.new_src_addr, want.new_src));
                    if (i_dec.hop_out !== want.hop_out)
                        report_mismatch($sformatf("hop_out got %0d want %0d",
                                                  i_dec.hop_out, want.hop_out));
                end
                decision_idx++;
            end
            if (i_hdr.valid && i_hdr.ready)
                awaited_decisions.push_back(relay_decision(i_hdr.dest_addr, i_hdr.hop_in,
                                                           i_hdr.reg_addr, i_hdr.func_code,
                                                           i_hdr.nonce, i_hdr.now_ms));
        end
        pending_cnt = awaited_decisions.size();
    end

endmodule

FILE: dv/tb_mesh_repeat_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// tb_mesh_repeat_duplicate_filter_top
// Drives packet headers into the duplicate filter with bursty pacing while
// the decision side stalls on its own pattern. A directed run covers the
// address, hop and expiry corners, wrapping time and ring eviction; random
// phases then replay a small pool of transactions under changing settings.
// ----------------------------------------------------------------------------
module tb_mesh_repeat_duplicate_filter_top
    import mrdf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 75;
    localparam int KEY_POOL      = 10;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mrdf_in_if  hdr_ch ();
    mrdf_out_if dec_ch ();

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // sender pacing and stimulus shaping
    int          burst_left = 0;
    bit          steady     = 1'b0;
    logic        cur_en;
    logic [7:0]  cur_own;
    logic [3:0]  cur_hops;
    logic [15:0] cur_exp;
    logic [31:0] clock_ms;
    logic [7:0]  pool_reg   [KEY_POOL];
    logic [7:0]  pool_func  [KEY_POOL];
    logic [7:0]  pool_nonce [KEY_POOL];

    mesh_repeat_duplicate_filter_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (hdr_ch),
        .o_out      (dec_ch)
    );

    mrdf_decision_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_hdr         (hdr_ch),
        .i_dec         (dec_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // decision side: stretches of free flow, random stalls and long hold-offs
    initial begin
        int mode;
        int span;
        dec_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(8, 30) : $urandom_range(20, 80);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: dec_ch.ready = 1'b1;
                    1: dec_ch.ready = 1'($urandom_range(0, 1));
                    2: dec_ch.ready = ($urandom_range(0, 3) == 0);
                    default: dec_ch.ready = 1'b0;
                endcase
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer, or after the idle gap that ends a burst
    task automatic offer_header(input logic [7:0] dest, input logic [3:0] hop,
                                input logic [7:0] rega, input logic [7:0] func,
                                input logic [7:0] nce, input logic [31:0] now);
        hdr_ch.valid     = 1'b1;
        hdr_ch.dest_addr = dest;
        hdr_ch.hop_in    = hop;
        hdr_ch.reg_addr  = rega;
        hdr_ch.func_code = func;
        hdr_ch.nonce     = nce;
        hdr_ch.now_ms    = now;
        do @(posedge i_clk); while (!hdr_ch.ready);
        @(negedge i_clk);
        if (burst_left > 0 || steady) begin
            burst_left--;
        end else begin
            hdr_ch.valid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        hdr_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
    endtask

    // upper data bits are junk, except for the full-width expiry, so the register width masking gets exercised
    task automatic set_config(input logic en, input logic [7:0] own,
                              input logic [3:0] hops, input logic [15:0] exp);
        wait_drained();
        write_reg(CFG_RELAY_EN, {15'($urandom), en});
        write_reg(CFG_OWN_ADDR, {8'($urandom), own});
        write_reg(CFG_MAX_HOPS, {12'($urandom), hops});
        write_reg(CFG_EXPIRY, exp);
        cfg_we   = 1'b0;
        cur_en   = en;
        cur_own  = own;
        cur_hops = hops;
        cur_exp  = exp;
    endtask

    task automatic run_directed();
        // reset settings: enabled, own address 1, hop limit 3, expiry 2000
        offer_header(8'd1, 4'd0, 8'h10, 8'h03, 8'h01, 32'd100);
        offer_header(8'd0, 4'd0, 8'h00, 8'h00, 8'h00, 32'd0);
        offer_header(8'd0, 4'd0, 8'h00, 8'h00, 8'h00, 32'd1999);
        offer_header(8'd0, 4'd1, 8'h00, 8'h00, 8'h00, 32'd2000);
        offer_header(8'd255, 4'd2, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // age wraps past zero
        offer_header(8'd255, 4'd0, 8'hFF, 8'hFF, 8'hFF, 32'd5);
        offer_header(8'd7, 4'd3, 8'h33, 8'h44, 8'h55, 32'd2001);
        offer_header(8'd7, 4'd15, 8'hA5, 8'h5A, 8'hC3, 32'd2001);
        offer_header(8'd7, 4'd2, 8'h00, 8'h00, 8'h01, 32'd2001);
        offer_header(8'd7, 4'd2, 8'h00, 8'h01, 8'h00, 32'd2002);
        offer_header(8'd7, 4'd2, 8'h01, 8'h00, 8'h00, 32'd2003);
        offer_header(8'd9, 4'd0, 8'h20, 8'h20, 8'h20, 32'd2004);
        offer_header(8'd9, 4'd0, 8'h21, 8'h21, 8'h21, 32'd2005);
        // ring is full, these two evict both copies of the all-zero key
        offer_header(8'd9, 4'd0, 8'h22, 8'h22, 8'h22, 32'd2006);
        offer_header(8'd9, 4'd0, 8'h23, 8'h23, 8'h23, 32'd2007);
        offer_header(8'd0, 4'd0, 8'h00, 8'h00, 8'h00, 32'd2100);
        set_config(1'b0, 8'd1, 4'd3, 16'd2000);
        offer_header(8'd0, 4'd0, 8'h66, 8'h77, 8'h88, 32'd2200);
        // zero expiry never sees a duplicate
        set_config(1'b1, 8'd0, 4'd15, 16'd0);
        offer_header(8'd5, 4'd0, 8'h00, 8'h00, 8'h00, 32'd2100);
        offer_header(8'd0, 4'd0, 8'h12, 8'h34, 8'h56, 32'd2300);
        offer_header(8'd255, 4'd14, 8'h12, 8'h34, 8'h56, 32'd2300);
        set_config(1'b1, 8'd255, 4'd0, 16'hFFFF);
        offer_header(8'd0, 4'd0, 8'h5A, 8'h5A, 8'h5A, 32'h8000_0000);
        set_config(1'b1, 8'd255, 4'd15, 16'hFFFF);
        offer_header(8'd255, 4'd0, 8'h5A, 8'h5A, 8'h5A, 32'h8000_0000);
        offer_header(8'd254, 4'd6, 8'h5A, 8'h5A, 8'h5A, 32'h8000_0000);
        offer_header(8'd254, 4'd6, 8'h5A, 8'h5A, 8'h5A, 32'h8000_FFFE);
        offer_header(8'd254, 4'd6, 8'h5A, 8'h5A, 8'h5A, 32'h8000_FFFF);
    endtask

    task automatic run_random_phase(input int phase);
        logic [15:0] exp;
        logic [7:0]  own;
        logic [3:0]  hops;
        logic [7:0]  dest;
        logic [3:0]  hop;
        logic [31:0] span;
        int          k;
        int          roll;
        case (phase % 4)
            0: exp = 16'($urandom_range(50, 3000));
            1: exp = 16'hFFFF;
            2: exp = 16'($urandom);
            default: exp = 16'd0;
        endcase
        case ($urandom_range(0, 2))
            0: own = 8'd0;
            1: own = 8'd255;
            default: own = 8'($urandom);
        endcase
        hops = (phase % 3 == 0) ? 4'd15 : 4'($urandom_range(1, 15));
        set_config(phase != 6, own, hops, exp);
        steady = (phase == 2);
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_reg[i]   = 8'($urandom);
            pool_func[i]  = 8'($urandom);
            pool_nonce[i] = 8'($urandom);
        end
        clock_ms = ($urandom_range(0, 1) == 1) ? 32'($urandom)
                                               : 32'hFFFF_FFFF - $urandom_range(0, 4000);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      span = $urandom_range(0, cur_exp / 4 + 1);
            else if (roll < 95) span = $urandom_range(0, 2 * cur_exp + 2);
            else                span = $urandom;
            clock_ms = clock_ms + span;
            dest = ($urandom_range(0, 99) < 15) ? cur_own : 8'($urandom);
            if (cur_hops != 0 && $urandom_range(0, 99) < 80)
                hop = 4'($urandom_range(0, cur_hops - 1));
            else
                hop = 4'($urandom_range(0, 15));
            k = $urandom_range(0, KEY_POOL - 1);
            if ($urandom_range(0, 99) < 80)
                offer_header(dest, hop, pool_reg[k], pool_func[k], pool_nonce[k], clock_ms);
            else
                offer_header(dest, hop, 8'($urandom), 8'($urandom), 8'($urandom),
                             clock_ms);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    initial begin
        cfg_we           = 1'b0;
        cfg_idx          = CFG_RELAY_EN;
        cfg_data         = '0;
        hdr_ch.valid     = 1'b0;
        hdr_ch.dest_addr = '0;
        hdr_ch.hop_in    = '0;
        hdr_ch.reg_addr  = '0;
        hdr_ch.func_code = '0;
        hdr_ch.nonce     = '0;
        hdr_ch.now_ms    = '0;
        cur_en           = RST_RELAY_EN;
        cur_own          = RST_OWN_ADDR;
        cur_hops         = RST_MAX_HOPS;
        cur_exp          = RST_EXPIRY;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);
        wait_drained();
        repeat (TABLE_DEPTH + 20) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mrdf_pkg.sv
rtl/core/mrdf_in_if.sv
rtl/core/mrdf_out_if.sv
rtl/core/mrdf_ctrl.sv
rtl/core/mrdf_dp.sv
rtl/core/mesh_repeat_duplicate_filter_top.sv
dv/mrdf_decision_checker.sv
dv/tb_mesh_repeat_duplicate_filter_top.sv
